FILE: rtl/modbus_request_frame_validator_macros.svh
// assertion macros shared by the frame validator checker
`ifndef MODBUS_REQUEST_FRAME_VALIDATOR_MACROS_SVH
`define MODBUS_REQUEST_FRAME_VALIDATOR_MACROS_SVH

// clocked property, switched off while reset is asserted
`define MBRFV_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every clock in which the given condition holds
`define MBRFV_ASSERT_RES(label, clk, rst_n, cond, prop, msg) \
	`MBRFV_ASSERT(label, clk, rst_n, (cond) |-> (prop), msg)

`endif

FILE: rtl/mbrfv_pkg.sv
// types and constants of the request frame validator
`timescale 1ns / 1ps

package mbrfv_pkg;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// summary status codes
	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_LENGTH  = 3'd1,
		ST_BAD_QTY     = 3'd2,
		ST_BAD_COIL    = 3'd3,
		ST_BC_MISMATCH = 3'd4,
		ST_LEN_MISMATCH = 3'd5,
		ST_UNSUPPORTED = 3'd6
	} status_t;

	// function codes
	localparam logic [7:0] FN_READ_COILS    = 8'd1;
	localparam logic [7:0] FN_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FN_READ_INPUTS   = 8'd4;
	localparam logic [7:0] FN_WRITE_COIL    = 8'd5;
	localparam logic [7:0] FN_WRITE_REG     = 8'd6;
	localparam logic [7:0] FN_WRITE_COILS   = 8'd15;
	localparam logic [7:0] FN_WRITE_REGS    = 8'd16;

	// quantity limits and fixed values
	localparam logic [15:0] MAX_READ_BITS  = 16'd2000;
	localparam logic [15:0] MAX_READ_REGS  = 16'd125;
	localparam logic [15:0] MAX_WRITE_BITS = 16'd1968;
	localparam logic [15:0] MAX_WRITE_REGS = 16'd123;
	localparam logic [15:0] COIL_ON        = 16'hFF00;

	// frame lengths, compared at a width that holds overhead plus byte count
	localparam int CMP_W = 10;
	localparam logic [CMP_W-1:0] LEN_SINGLE     = 10'd8;
	localparam logic [CMP_W-1:0] LEN_MIN_COILS  = 10'd10;
	localparam logic [CMP_W-1:0] LEN_MIN_REGS   = 10'd11;
	localparam logic [CMP_W-1:0] FRAME_OVERHEAD = 10'd9;

	// byte positions within a frame
	localparam int POS_FUNC       = 1;
	localparam int POS_ADDR_HI    = 2;
	localparam int POS_ADDR_LO    = 3;
	localparam int POS_COUNT_HI   = 4;
	localparam int POS_COUNT_LO   = 5;
	localparam int POS_DATA_BYTES = 6;
	localparam int POS_PAYLOAD    = 7;

	// header fields latched from a frame
	typedef struct packed {
		logic [7:0]  func;
		logic [15:0] addr;
		logic [15:0] count;
		logic [7:0]  data_bytes;
	} frame_t;

endpackage

FILE: rtl/modbus_request_frame_validator.sv
// top level of the request frame validator
`timescale 1ns / 1ps

// Request frame validator: takes frame bytes on the req channel and gives
// payload and summary results on the res channel, both valid/stall.
// A req beat carries one frame byte with first_byte on the slave id byte and
// last_byte on the final CRC byte. Write-multiple functions give one payload
// beat per coil byte (15) or per register word (16); the last byte gives one
// summary beat with the status and the latched header fields. Payload beats
// mean something only when the summary of their frame reports ok.
// A byte is held in the input register once accepted; its result is loaded
// from there into the result register, which drives the res channel.
// Throughput: one byte per cycle while the result channel is not stalled, set
// by the single pass from input register through the header update and
// checks into the result register.
// Reset clears the frame state and the valid bits of both registers; the next
// byte starts a frame. A stalled result holds; the input register still takes
// one more byte and req_stall rises only while both registers are full.

module modbus_request_frame_validator #(
	parameter int MAX_FRAME_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [7:0]  frame_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        result_kind,
	output logic [2:0]  status,
	output logic [7:0]  func_code,
	output logic [15:0] first_address,
	output logic [15:0] count_or_value,
	output logic [7:0]  declared_bytes,
	output logic [15:0] payload_value,
	output logic [7:0]  payload_index
);
	import mbrfv_pkg::*;

	localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        last_s1;

	// frame state
	frame_t      frame_q;
	logic [PW-1:0] pos_q;
	logic [7:0]  pend_q;
	logic [7:0]  pcnt_q;

	// result register
	logic        res_valid_q;
	logic        kind_q;
	status_t     status_q;
	frame_t      res_frame_q;
	logic [15:0] pval_q;
	logic [7:0]  pidx_q;

	// next-state signals
	frame_t      base_frame, nxt_frame;
	logic [PW-1:0] base_pos, nxt_pos;
	logic [7:0]  base_pend, nxt_pend;
	logic [7:0]  base_pcnt, nxt_pcnt;
	logic        multi;
	logic [CMP_W-1:0] off;
	logic        pay_hit;
	logic [15:0] pay_val;
	logic [7:0]  pay_idx;
	status_t     sum_status;
	logic        advance;
	logic        consume;

	// handshake
	assign advance   = !res_valid_q || !res_stall;
	assign consume   = valid_s1 && advance;
	assign req_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			byte_s1  <= frame_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
		end
	end

	// header latching and payload assembly for the byte in the input register
	always_comb begin
		base_frame = first_s1 ? '0 : frame_q;
		base_pos   = first_s1 ? '0 : pos_q;
		base_pend  = first_s1 ? '0 : pend_q;
		base_pcnt  = first_s1 ? '0 : pcnt_q;
		nxt_frame  = base_frame;
		nxt_pos    = base_pos;
		nxt_pend   = base_pend;
		nxt_pcnt   = base_pcnt;
		multi      = (base_frame.func == FN_WRITE_COILS) ||
		             (base_frame.func == FN_WRITE_REGS);
		off        = CMP_W'(base_pos) - CMP_W'(POS_PAYLOAD);
		pay_hit    = 1'b0;
		pay_val    = '0;
		pay_idx    = base_pcnt;
		if (base_pos < PW'(MAX_FRAME_BYTES)) begin
			case (base_pos)
				PW'(POS_FUNC):       nxt_frame.func = byte_s1;
				PW'(POS_ADDR_HI):    nxt_frame.addr[15:8] = byte_s1;
				PW'(POS_ADDR_LO):    nxt_frame.addr[7:0] = byte_s1;
				PW'(POS_COUNT_HI):   nxt_frame.count[15:8] = byte_s1;
				PW'(POS_COUNT_LO):   nxt_frame.count[7:0] = byte_s1;
				PW'(POS_DATA_BYTES): begin
					if (multi)
						nxt_frame.data_bytes = byte_s1;
				end
				default: begin
					if (base_pos >= PW'(POS_PAYLOAD) && multi &&
					    off < CMP_W'(base_frame.data_bytes)) begin
						if (base_frame.func == FN_WRITE_COILS) begin
							pay_hit  = 1'b1;
							pay_val  = {8'd0, byte_s1};
							nxt_pcnt = base_pcnt + 8'd1;
						end else if (!off[0]) begin
							nxt_pend = byte_s1;
						end else begin
							pay_hit  = 1'b1;
							pay_val  = {base_pend, byte_s1};
							nxt_pcnt = base_pcnt + 8'd1;
						end
					end
				end
			endcase
			nxt_pos = base_pos + PW'(1);
		end
	end

	// end-of-frame checks
	mbrfv_check #(
		.LEN_W(PW)
	) u_check (
		.fields   (nxt_frame),
		.frame_len(nxt_pos),
		.status   (sum_status)
	);

	// frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			pos_q   <= '0;
			pend_q  <= '0;
			pcnt_q  <= '0;
		end else if (consume) begin
			if (last_s1) begin
				frame_q <= '0;
				pos_q   <= '0;
				pend_q  <= '0;
				pcnt_q  <= '0;
			end else begin
				frame_q <= nxt_frame;
				pos_q   <= nxt_pos;
				pend_q  <= nxt_pend;
				pcnt_q  <= nxt_pcnt;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && (last_s1 || pay_hit);
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (consume && (last_s1 || pay_hit)) begin
			res_frame_q <= nxt_frame;
			if (last_s1) begin
				kind_q   <= KIND_SUMMARY;
				status_q <= sum_status;
				pval_q   <= '0;
				pidx_q   <= '0;
			end else begin
				kind_q   <= KIND_PAYLOAD;
				status_q <= ST_OK;
				pval_q   <= pay_val;
				pidx_q   <= pay_idx;
			end
		end
	end

	// outputs
	assign res_valid      = res_valid_q;
	assign result_kind    = kind_q;
	assign status         = status_q;
	assign func_code      = res_frame_q.func;
	assign first_address  = res_frame_q.addr;
	assign count_or_value = res_frame_q.count;
	assign declared_bytes = res_frame_q.data_bytes;
	assign payload_value  = pval_q;
	assign payload_index  = pidx_q;

endmodule

FILE: rtl/mbrfv_check.sv
// end-of-frame checks: length, quantity, coil value, byte count
`timescale 1ns / 1ps

module mbrfv_check #(
	parameter int LEN_W = 9
) (
	input  mbrfv_pkg::frame_t  fields,
	input  logic [LEN_W-1:0]   frame_len,
	output mbrfv_pkg::status_t status
);
	import mbrfv_pkg::*;

	logic [CMP_W-1:0] len;
	logic [CMP_W-1:0] exp_len;
	logic [15:0]      q;
	logic             q_zero;
	logic [15:0]      read_lim;
	logic [13:0]      coil_bytes;
	logic [16:0]      reg_bytes;

	// derived quantities
	always_comb begin
		len        = CMP_W'(frame_len);
		q          = fields.count;
		q_zero     = (q == 16'd0);
		read_lim   = (fields.func <= FN_READ_DISCRETE) ? MAX_READ_BITS : MAX_READ_REGS;
		coil_bytes = 14'((17'(q) + 17'd7) >> 3);
		reg_bytes  = {q, 1'b0};
		exp_len    = FRAME_OVERHEAD + CMP_W'(fields.data_bytes);
	end

	// checks in priority order per function
	always_comb begin
		status = ST_UNSUPPORTED;
		if (fields.func inside {[FN_READ_COILS:FN_READ_INPUTS]}) begin
			if (len != LEN_SINGLE)
				status = ST_BAD_LENGTH;
			else if (q_zero || q > read_lim)
				status = ST_BAD_QTY;
			else
				status = ST_OK;
		end else if (fields.func == FN_WRITE_COIL) begin
			if (len != LEN_SINGLE)
				status = ST_BAD_LENGTH;
			else if (!q_zero && q != COIL_ON)
				status = ST_BAD_COIL;
			else
				status = ST_OK;
		end else if (fields.func == FN_WRITE_REG) begin
			status = (len != LEN_SINGLE) ? ST_BAD_LENGTH : ST_OK;
		end else if (fields.func == FN_WRITE_COILS) begin
			if (len < LEN_MIN_COILS)
				status = ST_BAD_LENGTH;
			else if (q_zero || q > MAX_WRITE_BITS)
				status = ST_BAD_QTY;
			else if (14'(fields.data_bytes) != coil_bytes)
				status = ST_BC_MISMATCH;
			else if (len != exp_len)
				status = ST_LEN_MISMATCH;
			else
				status = ST_OK;
		end else if (fields.func == FN_WRITE_REGS) begin
			if (len < LEN_MIN_REGS)
				status = ST_BAD_LENGTH;
			else if (q_zero || q > MAX_WRITE_REGS)
				status = ST_BAD_QTY;
			else if (17'(fields.data_bytes) != reg_bytes)
				status = ST_BC_MISMATCH;
			else if (len != exp_len)
				status = ST_LEN_MISMATCH;
			else
				status = ST_OK;
		end
	end

endmodule

FILE: rtl/mbrfv_checker.sv
// port-level checks of the request frame validator, bound to the top level
`timescale 1ns / 1ps
`include "modbus_request_frame_validator_macros.svh"

module mbrfv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic        result_kind,
	input logic [2:0]  status,
	input logic [7:0]  func_code,
	input logic [15:0] count_or_value,
	input logic [7:0]  declared_bytes,
	input logic [15:0] payload_value,
	input logic [7:0]  payload_index
);
	import mbrfv_pkg::*;

	logic pay_beat;
	logic sum_beat;

	assign pay_beat = res_valid && (result_kind == KIND_PAYLOAD);
	assign sum_beat = res_valid && (result_kind == KIND_SUMMARY);

	// a stalled result beat holds
	`MBRFV_ASSERT(a_res_hold, clk, arst_n, res_valid && res_stall |=> res_valid && $stable(payload_value) && $stable(payload_index) && $stable(status), "stalled result beat changed")

	// payload beats only for write-multiple functions, status ok
	`MBRFV_ASSERT_RES(a_pay_func, clk, arst_n, pay_beat, status == ST_OK && (func_code == FN_WRITE_COILS || func_code == FN_WRITE_REGS), "payload beat for wrong function")

	// payload index stays inside the declared byte count
	`MBRFV_ASSERT_RES(a_pay_index, clk, arst_n, pay_beat, payload_index < declared_bytes, "payload index beyond byte count")

	// an ok register write frame declares two bytes per register
	`MBRFV_ASSERT_RES(a_sum_regs, clk, arst_n, sum_beat && func_code == FN_WRITE_REGS && status == ST_OK, declared_bytes == {count_or_value[6:0], 1'b0} && payload_value == 16'd0, "ok summary with bad byte count")

endmodule

bind modbus_request_frame_validator mbrfv_checker u_mbrfv_checker (.*);
